// ----- rtl/core/stk_pkg.sv -----
`default_nettype none
package stk_pkg;

	localparam int POS_W = 16;
	localparam int SPAN_W = 16;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_NUMBER = 2'd2;
	localparam logic [1:0] MODE_STRING = 2'd3;

	localparam logic [3:0] KIND_FUNC = 4'd0;
	localparam logic [3:0] KIND_IDENT = 4'd1;
	localparam logic [3:0] KIND_NUMBER = 4'd2;
	localparam logic [3:0] KIND_STRING = 4'd3;
	localparam logic [3:0] KIND_LPAREN = 4'd4;
	localparam logic [3:0] KIND_RPAREN = 4'd5;
	localparam logic [3:0] KIND_LBRACE = 4'd6;
	localparam logic [3:0] KIND_RBRACE = 4'd7;
	localparam logic [3:0] KIND_SEMI = 4'd8;
	localparam logic [3:0] KIND_ASSIGN = 4'd9;
	localparam logic [3:0] KIND_PLUS = 4'd10;
	localparam logic [3:0] KIND_MINUS = 4'd11;
	localparam logic [3:0] KIND_STAR = 4'd12;
	localparam logic [3:0] KIND_SLASH = 4'd13;
	localparam logic [3:0] KIND_END = 4'd14;
	localparam logic [3:0] KIND_NONE = 4'd15;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DOT = 2'd1;
	localparam logic [1:0] ERR_STRING = 2'd2;
	localparam logic [1:0] ERR_UNKNOWN = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;

	localparam logic [2:0] KW_LEN = 3'd4;

	typedef struct packed {
		logic [3:0]        kind;
		logic [SPAN_W-1:0] span_start;
		logic [SPAN_W-1:0] span_end;
		logic [1:0]        error_code;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h66;
			2'd1: c = 8'h75;
			2'd2: c = 8'h6E;
			default: c = 8'h63;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		logic [3:0] k;
		unique case (c)
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h7B: k = KIND_LBRACE;
			8'h7D: k = KIND_RBRACE;
			8'h3B: k = KIND_SEMI;
			8'h3D: k = KIND_ASSIGN;
			8'h2B: k = KIND_PLUS;
			8'h2D: k = KIND_MINUS;
			8'h2A: k = KIND_STAR;
			8'h2F: k = KIND_SLASH;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stk_scan.sv -----
`default_nettype none
module stk_scan (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 src_valid,
	output logic                src_stall,
	input  wire  [7:0]          ch,
	input  wire                 room,
	output stk_pkg::push_t      push
);
	import stk_pkg::*;

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              advance;

	logic [1:0]        mode_q, mode_n;
	logic [POS_W-1:0]  cursor_q, cursor_n;
	logic [POS_W-1:0]  tbeg_q, tbeg_n;
	logic              dot_q, dot_n;
	logic [2:0]        kp_q, kp_n;
	logic              miss_q, miss_n;
	logic              halt_q, halt_n;

	logic [POS_W-1:0]  cur_inc;
	logic              have_a, have_b, run_idle, kw_bad;
	tok_t              tok_a, tok_b;
	logic [3:0]        pk;

	assign advance = valid_s1 & room;
	assign src_stall = valid_s1 & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cursor_q <= '0;
			tbeg_q <= '0;
			dot_q <= 1'b0;
			kp_q <= '0;
			miss_q <= 1'b0;
			halt_q <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_n;
			cursor_q <= cursor_n;
			tbeg_q <= tbeg_n;
			dot_q <= dot_n;
			kp_q <= kp_n;
			miss_q <= miss_n;
			halt_q <= halt_n;
		end
	end

	assign cur_inc = cursor_q + POS_W'(1);
	assign pk = punct_kind(ch_s1);
	assign kw_bad = (kp_q >= KW_LEN) || (ch_s1 != kw_char(kp_q[1:0]));

	always_comb begin
		mode_n = mode_q;
		cursor_n = cursor_q;
		tbeg_n = tbeg_q;
		dot_n = dot_q;
		kp_n = kp_q;
		miss_n = miss_q;
		halt_n = halt_q;
		have_a = 1'b0;
		have_b = 1'b0;
		run_idle = 1'b0;
		tok_a = '0;
		tok_b = '0;

		if (!halt_q) begin
			unique case (mode_q)
				MODE_WORD: begin
					if (is_letter(ch_s1)) begin
						if (kw_bad) begin
							miss_n = 1'b1;
						end else begin
							kp_n = kp_q + 3'd1;
						end
						cursor_n = cur_inc;
					end else begin
						have_a = 1'b1;
						tok_a.kind = (!miss_q && kp_q == KW_LEN) ? KIND_FUNC : KIND_IDENT;
						tok_a.span_start = SPAN_W'(tbeg_q);
						tok_a.span_end = SPAN_W'(cursor_q);
						run_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(ch_s1)) begin
						cursor_n = cur_inc;
					end else if (ch_s1 == CH_DOT) begin
						if (dot_q) begin
							have_a = 1'b1;
							tok_a.kind = KIND_END;
							tok_a.span_start = SPAN_W'(tbeg_q);
							tok_a.span_end = SPAN_W'(cursor_q);
							tok_a.error_code = ERR_DOT;
							halt_n = 1'b1;
							mode_n = MODE_IDLE;
						end else begin
							dot_n = 1'b1;
							cursor_n = cur_inc;
						end
					end else begin
						have_a = 1'b1;
						tok_a.kind = KIND_NUMBER;
						tok_a.span_start = SPAN_W'(tbeg_q);
						tok_a.span_end = SPAN_W'(cursor_q);
						run_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					if (ch_s1 == CH_QUOTE) begin
						have_a = 1'b1;
						tok_a.kind = KIND_STRING;
						tok_a.span_start = SPAN_W'(tbeg_q);
						tok_a.span_end = SPAN_W'(cursor_q);
						cursor_n = cur_inc;
						mode_n = MODE_IDLE;
					end else if (ch_s1 == CH_NL || ch_s1 == CH_NUL) begin
						// A string left open at a newline or at the end of the source.
						have_a = 1'b1;
						tok_a.kind = KIND_END;
						tok_a.span_start = SPAN_W'(tbeg_q);
						tok_a.span_end = SPAN_W'(cursor_q);
						tok_a.error_code = ERR_STRING;
						halt_n = 1'b1;
						mode_n = MODE_IDLE;
					end else begin
						cursor_n = cur_inc;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			// The character that ends a run, or any character seen between tokens.
			if (run_idle) begin
				mode_n = MODE_IDLE;
				tok_b.span_start = SPAN_W'(cursor_q);
				tok_b.span_end = SPAN_W'(cur_inc);
				priority if (is_letter(ch_s1)) begin
					mode_n = MODE_WORD;
					tbeg_n = cursor_q;
					miss_n = (ch_s1 != kw_char(2'd0));
					kp_n = (ch_s1 != kw_char(2'd0)) ? 3'd0 : 3'd1;
					cursor_n = cur_inc;
				end else if (is_digit(ch_s1) || ch_s1 == CH_DOT) begin
					mode_n = MODE_NUMBER;
					tbeg_n = cursor_q;
					dot_n = (ch_s1 == CH_DOT);
					cursor_n = cur_inc;
				end else if (ch_s1 == CH_QUOTE) begin
					mode_n = MODE_STRING;
					tbeg_n = cur_inc;
					cursor_n = cur_inc;
				end else if (ch_s1 == CH_SPACE || ch_s1 == CH_TAB || ch_s1 == CH_NL ||
				             ch_s1 == CH_COMMA) begin
					cursor_n = cur_inc;
				end else if (ch_s1 == CH_NUL) begin
					have_b = 1'b1;
					tok_b.kind = KIND_END;
					tok_b.span_end = SPAN_W'(cursor_q);
					cursor_n = '0;
				end else if (pk != KIND_NONE) begin
					have_b = 1'b1;
					tok_b.kind = pk;
					cursor_n = cur_inc;
				end else begin
					have_b = 1'b1;
					tok_b.kind = KIND_END;
					tok_b.error_code = ERR_UNKNOWN;
					halt_n = 1'b1;
				end
			end
		end
	end

	always_comb begin
		push = '0;
		if (advance) begin
			push.count = {1'b0, have_a} + {1'b0, have_b};
		end
		if (have_a) begin
			push.tok0 = tok_a;
			push.tok0.last = ~have_b;
		end else begin
			push.tok0 = tok_b;
			push.tok0.last = 1'b1;
		end
		push.tok1 = tok_b;
		push.tok1.last = 1'b1;
	end

endmodule
`default_nettype wire

// ----- rtl/core/stk_outq.sv -----
`default_nettype none
module stk_outq (
	input  wire             clk,
	input  wire             arst_n,
	input  stk_pkg::push_t  push,
	output logic            room,
	output logic            tok_valid,
	input  wire             tok_stall,
	output stk_pkg::tok_t   tok
);
	import stk_pkg::*;

	tok_t        mem [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign tok_valid = (cnt_q != 3'd0);
	assign pop = tok_valid & ~tok_stall;
	// Two free entries cover the worst case of one character.
	assign room = (cnt_q <= 3'd2);
	assign tok = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wp_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem[wp_q + 2'd1] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push.count;
			rp_q <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/source_tokenizer_top.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// source    in         src_valid / src_stall  ch
// tokens    out        tok_valid / tok_stall  kind, span_start, span_end, error_code, last
//
// One character is taken per clock while src_stall is low. It is held in the input
// register, where the scanner decides its tokens and updates the scan state, and then
// lands in a four-entry result queue. A character that ends a run and is itself a
// token gives two results; they leave the queue one per clock while tok_stall is low.
// The input stalls only while the queue has fewer than two free entries.
// Reset (arst_n low) clears the scan state and empties the queue; no clearing pass.
module source_tokenizer_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         src_valid,
	output logic        src_stall,
	input  wire  [7:0]  ch,
	output logic        tok_valid,
	input  wire         tok_stall,
	output logic [3:0]  kind,
	output logic [15:0] span_start,
	output logic [15:0] span_end,
	output logic [1:0]  error_code,
	output logic        last
);
	import stk_pkg::*;

	push_t  push;
	logic   room;
	tok_t   tok;

	// Scanner: input register, mode logic and scan state.
	stk_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.ch        (ch),
		.room      (room),
		.push      (push)
	);

	// Result queue: decouples token delivery from character intake.
	stk_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

	assign kind = tok.kind;
	assign span_start = tok.span_start;
	assign span_end = tok.span_end;
	assign error_code = tok.error_code;
	assign last = tok.last;

endmodule
`default_nettype wire
